### rtl/cs_pkg.sv
package cs_pkg;

	localparam int MAX_ITEMS    = 4096;
	localparam int MAX_CELLS    = 4096;
	localparam int PAYLOAD_BITS = 64;

	localparam int KEY_W = 12;
	localparam int CNT_W = 13;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SORT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_BAD_KEY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
	localparam logic [STS_W-1:0] STS_BAD_RD  = 2'd3;

	// count and offset tables share one address
	typedef struct packed {
		logic             cnt_we;
		logic             off_we;
		logic [KEY_W-1:0] addr;
		logic [CNT_W-1:0] cnt_wd;
		logic [CNT_W-1:0] off_wd;
	} tbl_req_t;

	// input and output record stores; write data shared
	typedef struct packed {
		logic                    in_we;
		logic                    out_we;
		logic [KEY_W-1:0]        in_addr;
		logic [KEY_W-1:0]        out_addr;
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] pay;
	} rec_req_t;

endpackage

### rtl/cs_ifs.sv
interface cs_item_if;
	logic                            valid;
	logic                            ready;
	logic [cs_pkg::CMD_W-1:0]        command;
	logic [cs_pkg::KEY_W-1:0]        cell_key;
	logic [cs_pkg::PAYLOAD_BITS-1:0] payload;
	logic [cs_pkg::KEY_W-1:0]        position;

	modport source (output valid, command, cell_key, payload, position, input ready);
	modport sink (input valid, command, cell_key, payload, position, output ready);
endinterface

interface cs_result_if;
	logic                            valid;
	logic                            ready;
	logic [cs_pkg::STS_W-1:0]        status;
	logic [cs_pkg::KEY_W-1:0]        out_key;
	logic [cs_pkg::PAYLOAD_BITS-1:0] out_payload;
	logic [cs_pkg::CNT_W-1:0]        item_count;

	modport source (output valid, status, out_key, out_payload, item_count, input ready);
	modport sink (input valid, status, out_key, out_payload, item_count, output ready);
endinterface

### rtl/cs_count_tbl.sv
module cs_count_tbl (
	input  logic                     clk,
	input  cs_pkg::tbl_req_t         req,
	output logic [cs_pkg::CNT_W-1:0] cnt_rd,
	output logic [cs_pkg::CNT_W-1:0] off_rd
);

	logic [cs_pkg::CNT_W-1:0] cnt_mem [cs_pkg::MAX_CELLS];
	logic [cs_pkg::CNT_W-1:0] off_mem [cs_pkg::MAX_CELLS];

	always_ff @(posedge clk) begin
		if (req.cnt_we) begin
			cnt_mem[req.addr] <= req.cnt_wd;
		end
		cnt_rd <= cnt_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.off_we) begin
			off_mem[req.addr] <= req.off_wd;
		end
		off_rd <= off_mem[req.addr];
	end

endmodule

### rtl/cs_rec_store.sv
module cs_rec_store (
	input  logic                            clk,
	input  cs_pkg::rec_req_t                req,
	output logic [cs_pkg::KEY_W-1:0]        in_key_rd,
	output logic [cs_pkg::PAYLOAD_BITS-1:0] in_pay_rd,
	output logic [cs_pkg::KEY_W-1:0]        out_key_rd,
	output logic [cs_pkg::PAYLOAD_BITS-1:0] out_pay_rd
);

	logic [cs_pkg::KEY_W-1:0]        in_key_mem  [cs_pkg::MAX_ITEMS];
	logic [cs_pkg::PAYLOAD_BITS-1:0] in_pay_mem  [cs_pkg::MAX_ITEMS];
	logic [cs_pkg::KEY_W-1:0]        out_key_mem [cs_pkg::MAX_ITEMS];
	logic [cs_pkg::PAYLOAD_BITS-1:0] out_pay_mem [cs_pkg::MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (req.in_we) begin
			in_key_mem[req.in_addr] <= req.key;
			in_pay_mem[req.in_addr] <= req.pay;
		end
		in_key_rd <= in_key_mem[req.in_addr];
		in_pay_rd <= in_pay_mem[req.in_addr];
	end

	always_ff @(posedge clk) begin
		if (req.out_we) begin
			out_key_mem[req.out_addr] <= req.key;
			out_pay_mem[req.out_addr] <= req.pay;
		end
		out_key_rd <= out_key_mem[req.out_addr];
		out_pay_rd <= out_pay_mem[req.out_addr];
	end

endmodule

### rtl/counting_sort_by_cell_unit.sv
// Clear sweeps the count table one cell a cycle. Load bumps the cell's count and
// read returns a sorted record; errors answer straight from idle. Sort: a prefix
// pass over all 4096 cells, then a scatter per loaded record; one adder serves every sum.
// One word in flight at a time; the result register frees the input side.
// After reset the count table is swept over all 4096 cells, input not ready.
module counting_sort_by_cell_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [cs_pkg::CNT_W-1:0] cfg_wdata,
	cs_item_if.sink                  item,
	cs_result_if.source              result
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_CLR    = 4'd0;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
	localparam logic [ST_W-1:0] ST_LD_INC = 4'd2;
	localparam logic [ST_W-1:0] ST_PRE_RD = 4'd3;
	localparam logic [ST_W-1:0] ST_PRE_WR = 4'd4;
	localparam logic [ST_W-1:0] ST_SC_RD  = 4'd5;
	localparam logic [ST_W-1:0] ST_SC_OFF = 4'd6;
	localparam logic [ST_W-1:0] ST_SC_WR  = 4'd7;
	localparam logic [ST_W-1:0] ST_RD     = 4'd8;

	localparam logic [cs_pkg::KEY_W-1:0] CELL_LAST = cs_pkg::KEY_W'(cs_pkg::MAX_CELLS - 1);
	localparam logic [cs_pkg::CNT_W-1:0] CELLS_MAX = cs_pkg::CNT_W'(cs_pkg::MAX_CELLS);
	localparam logic [cs_pkg::CNT_W-1:0] ITEMS_MAX = cs_pkg::CNT_W'(cs_pkg::MAX_ITEMS);

	logic [ST_W-1:0]          state_q;
	logic [cs_pkg::KEY_W-1:0] idx_q;
	logic                     clr_cmd_q;
	logic [cs_pkg::CNT_W-1:0] loaded_q;
	logic                     sorted_q;
	logic                     ovalid_q;
	logic [cs_pkg::CNT_W-1:0] num_cells_q;

	logic [cs_pkg::KEY_W-1:0]        key_q;
	logic [cs_pkg::CNT_W-1:0]        run_q;
	logic [cs_pkg::STS_W-1:0]        status_q;
	logic [cs_pkg::KEY_W-1:0]        okey_q;
	logic [cs_pkg::PAYLOAD_BITS-1:0] opay_q;
	logic [cs_pkg::CNT_W-1:0]        ocount_q;

	cs_pkg::tbl_req_t tbl_req;
	cs_pkg::rec_req_t rec_req;

	logic [cs_pkg::CNT_W-1:0]        cnt_rd;
	logic [cs_pkg::CNT_W-1:0]        off_rd;
	logic [cs_pkg::KEY_W-1:0]        in_key_rd;
	logic [cs_pkg::PAYLOAD_BITS-1:0] in_pay_rd;
	logic [cs_pkg::KEY_W-1:0]        out_key_rd;
	logic [cs_pkg::PAYLOAD_BITS-1:0] out_pay_rd;

	logic [cs_pkg::CNT_W-1:0] cells_use;
	logic [cs_pkg::CNT_W-1:0] idx_nx;
	logic                     acc;
	logic                     key_ok;
	logic                     full;
	logic                     rd_ok;
	logic [cs_pkg::CNT_W-1:0] add_a;
	logic [cs_pkg::CNT_W-1:0] add_b;
	logic [cs_pkg::CNT_W-1:0] sum;

	logic                            resp_fire;
	logic [cs_pkg::STS_W-1:0]        resp_status;
	logic [cs_pkg::KEY_W-1:0]        resp_key;
	logic [cs_pkg::PAYLOAD_BITS-1:0] resp_pay;
	logic [cs_pkg::CNT_W-1:0]        resp_count;

	cs_count_tbl u_tbl (
		.clk    (clk),
		.req    (tbl_req),
		.cnt_rd (cnt_rd),
		.off_rd (off_rd)
	);

	cs_rec_store u_rec (
		.clk        (clk),
		.req        (rec_req),
		.in_key_rd  (in_key_rd),
		.in_pay_rd  (in_pay_rd),
		.out_key_rd (out_key_rd),
		.out_pay_rd (out_pay_rd)
	);

	assign cells_use = (num_cells_q > CELLS_MAX) ? CELLS_MAX : num_cells_q;
	assign idx_nx    = {1'b0, idx_q} + cs_pkg::CNT_W'(1);
	assign item.ready = (state_q == ST_IDLE) && (!ovalid_q || result.ready);
	assign acc       = item.valid && item.ready;
	assign key_ok    = {1'b0, item.cell_key} < cells_use;
	assign full      = loaded_q == ITEMS_MAX;
	assign rd_ok     = sorted_q && ({1'b0, item.position} < loaded_q);

	// shared adder: prefix run, count bump, offset bump
	always_comb begin
		case (state_q)
			ST_LD_INC: begin
				add_a = cnt_rd;
				add_b = cs_pkg::CNT_W'(1);
			end
			ST_PRE_WR: begin
				add_a = run_q;
				add_b = cnt_rd;
			end
			ST_SC_WR: begin
				add_a = off_rd;
				add_b = cs_pkg::CNT_W'(1);
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end
	assign sum = add_a + add_b;

	always_comb begin
		tbl_req        = '0;
		tbl_req.addr   = idx_q;
		rec_req          = '0;
		rec_req.in_addr  = idx_q;
		rec_req.out_addr = item.position;
		rec_req.key      = item.cell_key;
		rec_req.pay      = item.payload;
		case (state_q)
			ST_CLR: begin
				tbl_req.cnt_we = 1'b1;
			end
			ST_IDLE: begin
				tbl_req.addr    = item.cell_key;
				rec_req.in_addr = loaded_q[cs_pkg::KEY_W-1:0];
				rec_req.in_we   = acc && (item.command == cs_pkg::CMD_LOAD)
					&& key_ok && !full;
			end
			ST_LD_INC: begin
				tbl_req.addr   = key_q;
				tbl_req.cnt_we = 1'b1;
				tbl_req.cnt_wd = sum;
			end
			ST_PRE_WR: begin
				tbl_req.off_we = 1'b1;
				tbl_req.off_wd = run_q;
			end
			ST_SC_OFF: begin
				tbl_req.addr = in_key_rd;
			end
			ST_SC_WR: begin
				tbl_req.addr     = in_key_rd;
				tbl_req.off_we   = 1'b1;
				tbl_req.off_wd   = sum;
				rec_req.out_we   = 1'b1;
				rec_req.out_addr = off_rd[cs_pkg::KEY_W-1:0];
				rec_req.key      = in_key_rd;
				rec_req.pay      = in_pay_rd;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		resp_fire   = 1'b0;
		resp_status = cs_pkg::STS_OK;
		resp_key    = '0;
		resp_pay    = '0;
		resp_count  = loaded_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (item.command)
						cs_pkg::CMD_LOAD: begin
							if (!key_ok) begin
								resp_fire   = 1'b1;
								resp_status = cs_pkg::STS_BAD_KEY;
							end else if (full) begin
								resp_fire   = 1'b1;
								resp_status = cs_pkg::STS_FULL;
							end
						end
						cs_pkg::CMD_READ: begin
							if (!rd_ok) begin
								resp_fire   = 1'b1;
								resp_status = cs_pkg::STS_BAD_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CLR: begin
				resp_fire  = clr_cmd_q && (idx_q == CELL_LAST);
				resp_count = '0;
			end
			ST_LD_INC: begin
				resp_fire  = 1'b1;
				resp_count = loaded_q + cs_pkg::CNT_W'(1);
			end
			ST_PRE_WR: begin
				resp_fire = (idx_q == CELL_LAST) && (loaded_q == '0);
			end
			ST_SC_WR: begin
				resp_fire = idx_nx == loaded_q;
			end
			ST_RD: begin
				resp_fire = 1'b1;
				resp_key  = out_key_rd;
				resp_pay  = out_pay_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			clr_cmd_q   <= 1'b0;
			loaded_q    <= '0;
			sorted_q    <= 1'b0;
			ovalid_q    <= 1'b0;
			num_cells_q <= CELLS_MAX;
		end else begin
			if (cfg_we) begin
				num_cells_q <= cfg_wdata;
			end
			ovalid_q <= resp_fire || (ovalid_q && !result.ready);
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + cs_pkg::KEY_W'(1);
					if (idx_q == CELL_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (item.command)
							cs_pkg::CMD_CLEAR: begin
								state_q   <= ST_CLR;
								idx_q     <= '0;
								clr_cmd_q <= 1'b1;
								loaded_q  <= '0;
								sorted_q  <= 1'b0;
							end
							cs_pkg::CMD_LOAD: begin
								if (key_ok && !full) begin
									state_q <= ST_LD_INC;
								end
							end
							cs_pkg::CMD_SORT: begin
								state_q <= ST_PRE_RD;
								idx_q   <= '0;
							end
							cs_pkg::CMD_READ: begin
								if (rd_ok) begin
									state_q <= ST_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LD_INC: begin
					loaded_q <= loaded_q + cs_pkg::CNT_W'(1);
					sorted_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				ST_PRE_RD: begin
					state_q <= ST_PRE_WR;
				end
				ST_PRE_WR: begin
					// index wraps to zero after the last cell, ready for the scatter
					idx_q <= idx_q + cs_pkg::KEY_W'(1);
					if (idx_q == CELL_LAST) begin
						if (loaded_q == '0) begin
							sorted_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_SC_RD;
						end
					end else begin
						state_q <= ST_PRE_RD;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_OFF;
				end
				ST_SC_OFF: begin
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					idx_q <= idx_nx[cs_pkg::KEY_W-1:0];
					if (idx_nx == loaded_q) begin
						sorted_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SC_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= item.cell_key;
		end
		if (state_q == ST_IDLE) begin
			run_q <= '0;
		end else if (state_q == ST_PRE_WR) begin
			run_q <= sum;
		end
		if (resp_fire) begin
			status_q <= resp_status;
			okey_q   <= resp_key;
			opay_q   <= resp_pay;
			ocount_q <= resp_count;
		end
	end

	assign result.valid       = ovalid_q;
	assign result.status      = status_q;
	assign result.out_key     = okey_q;
	assign result.out_payload = opay_q;
	assign result.item_count  = ocount_q;

endmodule

### tb/testbench.sv
module testbench;
	import cs_pkg::*;

	typedef struct packed {
		logic [STS_W-1:0]        status;
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [CNT_W-1:0]        count;
	} answer_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	cs_item_if   item ();
	cs_result_if result ();

	counting_sort_by_cell_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.result    (result)
	);

	// shadow copy of the sorter's tables
	logic [CNT_W-1:0]        cell_tally [MAX_CELLS];
	logic [KEY_W-1:0]        stored_key [MAX_ITEMS];
	logic [PAYLOAD_BITS-1:0] stored_pay [MAX_ITEMS];
	logic [KEY_W-1:0]        sorted_key [MAX_ITEMS];
	logic [PAYLOAD_BITS-1:0] sorted_pay [MAX_ITEMS];
	int unsigned             records_held;
	bit                      order_valid;
	int unsigned             cells_cfg;

	answer_t     expected_answers [$];
	int unsigned words_sent;
	int unsigned mismatches;
	int unsigned idle_pct;
	int unsigned stall_pct;

	always #4 clk = ~clk;

	function automatic answer_t predict_answer(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
			logic [PAYLOAD_BITS-1:0] pay, logic [KEY_W-1:0] pos);
		answer_t     a;
		int unsigned next_slot [MAX_CELLS];
		int unsigned run;
		int unsigned dst;
		int unsigned lim;
		a = '0;
		case (cmd)
		CMD_CLEAR: begin
			foreach (cell_tally[c]) cell_tally[c] = '0;
			records_held = 0;
			order_valid = 1'b0;
		end
		CMD_LOAD: begin
			lim = (cells_cfg < MAX_CELLS) ? cells_cfg : MAX_CELLS;
			// range check wins over the full check
			if (key >= lim) begin
				a.status = STS_BAD_KEY;
			end else if (records_held >= MAX_ITEMS) begin
				a.status = STS_FULL;
			end else begin
				stored_key[records_held] = key;
				stored_pay[records_held] = pay;
				records_held++;
				cell_tally[key] = cell_tally[key] + CNT_W'(1);
				order_valid = 1'b0;
			end
		end
		CMD_SORT: begin
			// exclusive prefix over every cell, whatever num_cells is now
			run = 0;
			for (int c = 0; c < MAX_CELLS; c++) begin
				next_slot[c] = run;
				run += 32'(cell_tally[c]);
			end
			for (int i = 0; i < records_held; i++) begin
				dst = next_slot[stored_key[i]];
				sorted_key[dst] = stored_key[i];
				sorted_pay[dst] = stored_pay[i];
				next_slot[stored_key[i]] = dst + 1;
			end
			order_valid = 1'b1;
		end
		default: begin
			if (!order_valid || pos >= records_held) begin
				a.status = STS_BAD_RD;
			end else begin
				a.key = sorted_key[pos];
				a.payload = sorted_pay[pos];
			end
		end
		endcase
		a.count = records_held[CNT_W-1:0];
		return a;
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return {$urandom(), $urandom()};
	endfunction

	function automatic int unsigned pick_cells();
		int unsigned r;
		r = $urandom_range(3);
		if (r == 0) return MAX_CELLS;
		if (r == 1) return 1;
		if (r == 2) return $urandom_range(64, 2);
		return $urandom_range(MAX_CELLS, 1);
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return KEY_W'($urandom_range(MAX_CELLS - 1));
	endfunction

	function automatic logic [KEY_W-1:0] rand_pos();
		return KEY_W'($urandom_range(MAX_ITEMS - 1));
	endfunction

	task automatic issue_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
			logic [PAYLOAD_BITS-1:0] pay, logic [KEY_W-1:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid    <= 1'b1;
		item.command  <= cmd;
		item.cell_key <= key;
		item.payload  <= pay;
		item.position <= pos;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		expected_answers.push_back(predict_answer(cmd, key, pay, pos));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item.valid <= 1'b0;
		do @(negedge clk); while (expected_answers.size() != 0);
	endtask

	// only called with the block idle
	task automatic set_cells(int unsigned n);
		cfg_we    <= 1'b1;
		cfg_wdata <= n[CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cells_cfg = n;
		@(negedge clk);
	endtask

	task automatic load_record();
		logic [KEY_W-1:0] k;
		if (cells_cfg < MAX_CELLS && $urandom_range(9) == 0)
			k = KEY_W'($urandom_range(MAX_CELLS - 1, cells_cfg));
		else
			k = KEY_W'($urandom_range(cells_cfg - 1));
		issue_command(CMD_LOAD, k, rand_payload(), rand_pos());
	endtask

	task automatic read_record();
		logic [KEY_W-1:0] p;
		if (order_valid && records_held != 0 && $urandom_range(7) != 0)
			p = KEY_W'($urandom_range(records_held - 1));
		else
			p = rand_pos();
		issue_command(CMD_READ, rand_key(), rand_payload(), p);
	endtask

	task automatic test_empty_state();
		issue_command(CMD_READ, '0, '0, '0);
		issue_command(CMD_SORT, '1, '1, '1);
		issue_command(CMD_READ, '0, '0, '0);
		issue_command(CMD_READ, '1, '1, '1);
		issue_command(CMD_CLEAR, '1, '1, '1);
		wait_drained();
		set_cells(MAX_CELLS);
	endtask

	task automatic test_stable_order();
		issue_command(CMD_LOAD, 12'hfff, '1, '0);
		issue_command(CMD_LOAD, 12'h000, '0, '1);
		issue_command(CMD_LOAD, 12'hfff, 64'h5555_5555_5555_5555, 12'h555);
		issue_command(CMD_LOAD, 12'h000, '1, 12'haaa);
		issue_command(CMD_LOAD, 12'haaa, 64'haaaa_aaaa_aaaa_aaaa, '0);
		issue_command(CMD_LOAD, 12'h555, rand_payload(), '0);
		issue_command(CMD_SORT, '0, '0, '0);
		// counts survive a sort, so a second one gives the same order
		issue_command(CMD_SORT, '0, '0, '0);
		for (int p = 0; p < 7; p++) issue_command(CMD_READ, '0, '0, KEY_W'(p));
		issue_command(CMD_READ, '0, '0, '1);
	endtask

	task automatic test_load_after_sort();
		issue_command(CMD_LOAD, 12'd7, rand_payload(), '0);
		issue_command(CMD_READ, '0, '0, '0);
		issue_command(CMD_SORT, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, 12'd6);
	endtask

	task automatic test_key_range();
		wait_drained();
		set_cells(1);
		issue_command(CMD_LOAD, 12'd1, rand_payload(), '0);
		issue_command(CMD_LOAD, 12'hfff, rand_payload(), '0);
		issue_command(CMD_LOAD, 12'd0, rand_payload(), '0);
		// records above the new cell count must still come out
		issue_command(CMD_SORT, '0, '0, '0);
		for (int p = 0; p < records_held; p++) issue_command(CMD_READ, '0, '0, KEY_W'(p));
		wait_drained();
		set_cells(MAX_CELLS);
	endtask

	task automatic test_clear();
		issue_command(CMD_CLEAR, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0);
		issue_command(CMD_LOAD, 12'd3, rand_payload(), '0);
		issue_command(CMD_CLEAR, '0, '0, '0);
		issue_command(CMD_SORT, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0);
	endtask

	task automatic test_buffer_full();
		wait_drained();
		idle_pct = 0;
		stall_pct = 0;
		set_cells(MAX_CELLS);
		issue_command(CMD_CLEAR, '0, '0, '0);
		repeat (MAX_ITEMS) load_record();
		issue_command(CMD_LOAD, 12'd5, rand_payload(), '0);
		wait_drained();
		set_cells(100);
		issue_command(CMD_LOAD, 12'd200, rand_payload(), '0);
		issue_command(CMD_LOAD, 12'd5, rand_payload(), '0);
		issue_command(CMD_SORT, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '1);
		repeat (20) read_record();
		issue_command(CMD_CLEAR, '0, '0, '0);
	endtask

	task automatic run_sequence();
		int unsigned n;
		if ($urandom_range(4) == 0) begin
			wait_drained();
			set_cells(pick_cells());
		end
		if ($urandom_range(1) == 0)
			issue_command(CMD_CLEAR, rand_key(), rand_payload(), rand_pos());
		n = $urandom_range(30, 1);
		repeat (n) load_record();
		if ($urandom_range(3) == 0)
			issue_command(CMD_W'($urandom_range(3)), rand_key(), rand_payload(),
				rand_pos());
		issue_command(CMD_SORT, rand_key(), rand_payload(), rand_pos());
		repeat (n + 2) read_record();
		if ($urandom_range(6) == 0) begin
			load_record();
			read_record();
		end
	endtask

	task automatic test_random_traffic();
		int unsigned idle_by_phase [4] = '{0, 69, 0, 8};
		int unsigned stall_by_phase [4] = '{0, 0, 69, 8};
		int unsigned phase_start;
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			if (ph == 0)
				set_cells(MAX_CELLS);
			else if (ph == 1)
				set_cells(1);
			else
				set_cells(pick_cells());
			phase_start = words_sent;
			while (words_sent - phase_start < 340) run_sequence();
		end
	endtask

	always @(negedge clk) result.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_answers
		answer_t want;
		answer_t got;
		if (arst_n && result.valid && result.ready) begin
			got.status = result.status;
			got.key = result.out_key;
			got.payload = result.out_payload;
			got.count = result.item_count;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sts %0d key %0d pay %h cnt %0d",
						got.status, got.key, got.payload, got.count);
			end else begin
				want = expected_answers.pop_front();
				if (got.status !== want.status || got.key !== want.key
						|| got.payload !== want.payload || got.count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected sts %0d key %0d pay %h cnt %0d,",
							want.status, want.key, want.payload, want.count,
							" got sts %0d key %0d pay %h cnt %0d",
							got.status, got.key, got.payload, got.count);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item.valid = 1'b0;
		item.command = CMD_CLEAR;
		item.cell_key = '0;
		item.payload = '0;
		item.position = '0;
		result.ready = 1'b0;
		foreach (cell_tally[c]) cell_tally[c] = '0;
		records_held = 0;
		order_valid = 1'b0;
		cells_cfg = MAX_CELLS;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		words_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_empty_state();
		test_stable_order();
		test_load_after_sort();
		test_key_range();
		test_clear();
		test_buffer_full();
		test_random_traffic();

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

endmodule
